FILE: design/fcce_pkg.sv
// Shared types and constants for the FAT16 cluster chain engine.
// No dependencies; every other design file except fcce_ram refers to it by scoped names.
`timescale 1ns / 1ps

package fcce_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int CL_W        = 16;
    localparam int CMP_W       = CL_W + 1;
    localparam int EIU_W       = 17;
    localparam int LG_W        = 3;
    localparam int PAGE_W      = (1 << LG_W) - 1;
    localparam int SECTOR_SHIFT = 9;
    localparam int BYTE_W      = SECTOR_SHIFT;
    localparam int OFF_W       = 32;
    localparam int HOP_W       = OFF_W - SECTOR_SHIFT;
    localparam int SEC_W       = 32;

    localparam logic [CL_W-1:0]  END_MARK  = 16'hFFFF;
    localparam logic [EIU_W-1:0] EIU_RESET = 17'd4096;

    // Operation codes carried on s_tuser
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_LOCATE = 2'd2,
        OP_ALLOC  = 2'd3
    } op_t;

    // Result status carried on m_tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_END   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Register word indexes on the APB port
    typedef enum logic [1:0] {
        REG_DATA_START = 2'd0,
        REG_SEC_LOG2   = 2'd1,
        REG_ENTRIES    = 2'd2
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_WALK,
        S_LOC_END,
        S_SCAN,
        S_MARK,
        S_LINK,
        S_RESP
    } state_t;

    // Configuration as seen by the sequencer
    typedef struct packed {
        logic [SEC_W-1:0] data_start;
        logic [LG_W-1:0]  sec_log2;
        logic [CNT_W-1:0] usable;      // min(entries_in_use, TABLE_DEPTH)
    } cfg_t;

    // Table memory request
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CL_W-1:0]   wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

FILE: design/fcce_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module fcce_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered data
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/fcce_cfg.sv
// APB configuration registers of the cluster chain engine.
// Depends on fcce_pkg for register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module fcce_cfg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output fcce_pkg::cfg_t      cfg
);

    logic [31:0]                       data_start_reg, data_start_next;
    logic [fcce_pkg::LG_W-1:0]         sec_log2_reg, sec_log2_next;
    logic [fcce_pkg::EIU_W-1:0]        entries_reg, entries_next;
    logic                              wr_en;
    fcce_pkg::reg_idx_t                idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = fcce_pkg::reg_idx_t'(paddr[3:2]);

    // Register writes
    always_comb begin
        data_start_next = data_start_reg;
        sec_log2_next   = sec_log2_reg;
        entries_next    = entries_reg;
        if (wr_en && paddr[3:2] == fcce_pkg::REG_DATA_START) begin
            data_start_next = pwdata;
        end
        if (wr_en && paddr[3:2] == fcce_pkg::REG_SEC_LOG2) begin
            sec_log2_next = pwdata[fcce_pkg::LG_W-1:0];
        end
        if (wr_en && paddr[3:2] == fcce_pkg::REG_ENTRIES) begin
            entries_next = pwdata[fcce_pkg::EIU_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_start_reg <= '0;
            sec_log2_reg   <= '0;
            entries_reg    <= fcce_pkg::EIU_RESET;
        end else begin
            data_start_reg <= data_start_next;
            sec_log2_reg   <= sec_log2_next;
            entries_reg    <= entries_next;
        end
    end

    // Read back
    always_comb begin
        case (idx)
            fcce_pkg::REG_DATA_START: prdata = data_start_reg;
            fcce_pkg::REG_SEC_LOG2:   prdata = 32'(sec_log2_reg);
            fcce_pkg::REG_ENTRIES:    prdata = 32'(entries_reg);
            default:                  prdata = '0;
        endcase
    end

    // Configuration bundle; usable entry count clipped to the table depth
    assign cfg.data_start = data_start_reg;
    assign cfg.sec_log2   = sec_log2_reg;
    assign cfg.usable     = (entries_reg > fcce_pkg::EIU_W'(fcce_pkg::TABLE_DEPTH))
                          ? fcce_pkg::CNT_W'(fcce_pkg::TABLE_DEPTH)
                          : entries_reg[fcce_pkg::CNT_W-1:0];

endmodule

FILE: design/fcce_ctrl.sv
// Sequencer of the cluster chain engine: dispatch, chain walk, free scan, result stage.
// Depends on fcce_pkg; drives the table RAM through a ram_req_t bundle.
`timescale 1ns / 1ps

module fcce_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fcce_pkg::cfg_t                    cfg,
    // input transactions
    input  logic                              s_valid,
    output logic                              s_ready,
    input  fcce_pkg::op_t                     s_op,
    input  logic [fcce_pkg::CL_W-1:0]         s_cluster,
    input  logic [fcce_pkg::CL_W-1:0]         s_entry_value,
    input  logic [fcce_pkg::OFF_W-1:0]        s_offset,
    // result transactions
    output logic                              m_valid,
    input  logic                              m_ready,
    output fcce_pkg::status_t                 m_status,
    output logic [fcce_pkg::CL_W-1:0]         m_cluster_out,
    output logic [fcce_pkg::SEC_W-1:0]        m_sector,
    output logic [fcce_pkg::BYTE_W-1:0]       m_byte_in_sector,
    // table memory
    output fcce_pkg::ram_req_t                ram_req,
    input  logic [fcce_pkg::CL_W-1:0]         ram_rdata
);

    localparam int ADDR_W = fcce_pkg::ADDR_W;
    localparam int CNT_W  = fcce_pkg::CNT_W;
    localparam int CL_W   = fcce_pkg::CL_W;
    localparam int CMP_W  = fcce_pkg::CMP_W;
    localparam int HOP_W  = fcce_pkg::HOP_W;
    localparam int PAGE_W = fcce_pkg::PAGE_W;
    localparam int BYTE_W = fcce_pkg::BYTE_W;
    localparam int SEC_W  = fcce_pkg::SEC_W;
    localparam int SSH    = fcce_pkg::SECTOR_SHIFT;

    fcce_pkg::state_t      state_reg, state_next;

    // latched item
    fcce_pkg::op_t         op_reg, op_next;
    logic [CL_W-1:0]       cl_reg, cl_next;
    logic [CL_W-1:0]       val_reg, val_next;
    logic [31:0]           off_reg, off_next;

    // walk and scan state
    logic [HOP_W-1:0]      hops_reg, hops_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic [BYTE_W-1:0]     byte_reg, byte_next;
    logic [CL_W-1:0]       cur_reg, cur_next;
    logic                  walk_ram_reg, walk_ram_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_W-1:0]     pidx_reg, pidx_next;

    // pending result
    fcce_pkg::status_t     rst_reg, rst_next;
    logic [CL_W-1:0]       rcl_reg, rcl_next;
    logic [SEC_W-1:0]      rsec_reg, rsec_next;
    logic [BYTE_W-1:0]     rbyte_reg, rbyte_next;

    // output register
    logic                  mv_reg, mv_next;
    fcce_pkg::status_t     ost_reg, ost_next;
    logic [CL_W-1:0]       ocl_reg, ocl_next;
    logic [SEC_W-1:0]      osec_reg, osec_next;
    logic [BYTE_W-1:0]     obyte_reg, obyte_next;

    // decoded conditions
    logic                  accept;
    logic                  out_load;
    logic                  cl_oor;
    logic [CL_W-1:0]       cur;
    logic                  cur_oor;
    logic                  cur_end;
    logic                  end_oor;
    logic                  end_end;
    logic                  scan_hit;
    logic                  scan_more;
    logic [ADDR_W-1:0]     rel;
    logic [SEC_W-1:0]      sec_base;

    assign s_ready  = (state_reg == fcce_pkg::S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == fcce_pkg::S_RESP) && (!mv_reg || m_ready);

    assign cl_oor    = CMP_W'(cl_reg) >= CMP_W'(cfg.usable);
    // chain follows RAM data right after a hop read
    assign cur       = walk_ram_reg ? ram_rdata : cur_reg;
    assign cur_end   = (cur == fcce_pkg::END_MARK);
    assign cur_oor   = CMP_W'(cur) >= CMP_W'(cfg.usable);
    assign end_end   = (cur_reg == fcce_pkg::END_MARK);
    assign end_oor   = (CMP_W'(cur_reg) >= CMP_W'(cfg.usable)) || (cur_reg < CL_W'(2));
    assign scan_hit  = pend_reg && (ram_rdata == '0);
    assign scan_more = scan_reg < cfg.usable;
    assign rel       = cur_reg[ADDR_W-1:0] - ADDR_W'(2);
    assign sec_base  = SEC_W'(rel) << cfg.sec_log2;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            fcce_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = fcce_pkg::S_DISPATCH;
                end
            end
            fcce_pkg::S_DISPATCH: begin
                case (op_reg)
                    fcce_pkg::OP_WRITE:  state_next = fcce_pkg::S_RESP;
                    fcce_pkg::OP_READ:   state_next = cl_oor ? fcce_pkg::S_RESP
                                                             : fcce_pkg::S_RD_WAIT;
                    fcce_pkg::OP_LOCATE: state_next = fcce_pkg::S_WALK;
                    fcce_pkg::OP_ALLOC:  state_next = (cl_reg != '0 && cl_oor)
                                                    ? fcce_pkg::S_RESP : fcce_pkg::S_SCAN;
                    default:             state_next = fcce_pkg::S_RESP;
                endcase
            end
            fcce_pkg::S_RD_WAIT: state_next = fcce_pkg::S_RESP;
            fcce_pkg::S_WALK: begin
                if (hops_reg == '0) begin
                    state_next = fcce_pkg::S_LOC_END;
                end else if (cur_end || cur_oor) begin
                    state_next = fcce_pkg::S_RESP;
                end
            end
            fcce_pkg::S_LOC_END: state_next = fcce_pkg::S_RESP;
            fcce_pkg::S_SCAN: begin
                if (scan_hit) begin
                    state_next = fcce_pkg::S_MARK;
                end else if (!scan_more && !pend_reg) begin
                    state_next = fcce_pkg::S_RESP;
                end
            end
            fcce_pkg::S_MARK: state_next = (cl_reg != '0) ? fcce_pkg::S_LINK
                                                          : fcce_pkg::S_RESP;
            fcce_pkg::S_LINK: state_next = fcce_pkg::S_RESP;
            fcce_pkg::S_RESP: begin
                if (out_load) begin
                    state_next = fcce_pkg::S_IDLE;
                end
            end
            default: state_next = fcce_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory requests
    always_comb begin
        op_next       = op_reg;
        cl_next       = cl_reg;
        val_next      = val_reg;
        off_next      = off_reg;
        hops_next     = hops_reg;
        page_next     = page_reg;
        byte_next     = byte_reg;
        cur_next      = cur_reg;
        walk_ram_next = walk_ram_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        rst_next      = rst_reg;
        rcl_next      = rcl_reg;
        rsec_next     = rsec_reg;
        rbyte_next    = rbyte_reg;
        ram_req       = '0;

        case (state_reg)
            fcce_pkg::S_IDLE: begin
                if (accept) begin
                    op_next  = s_op;
                    cl_next  = s_cluster;
                    val_next = s_entry_value;
                    off_next = s_offset;
                end
                rst_next   = fcce_pkg::ST_OK;
                rcl_next   = '0;
                rsec_next  = '0;
                rbyte_next = '0;
            end
            fcce_pkg::S_DISPATCH: begin
                case (op_reg)
                    fcce_pkg::OP_WRITE: begin
                        if (cl_oor) begin
                            rst_next = fcce_pkg::ST_RANGE;
                        end else begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = cl_reg[ADDR_W-1:0];
                            ram_req.wdata = val_reg;
                            rcl_next      = cl_reg;
                        end
                    end
                    fcce_pkg::OP_READ: begin
                        if (cl_oor) begin
                            rst_next = fcce_pkg::ST_RANGE;
                        end else begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = cl_reg[ADDR_W-1:0];
                        end
                    end
                    fcce_pkg::OP_LOCATE: begin
                        hops_next     = HOP_W'(off_reg[31:SSH] >> cfg.sec_log2);
                        page_next     = off_reg[SSH +: PAGE_W]
                                      & ((PAGE_W'(1) << cfg.sec_log2) - PAGE_W'(1));
                        byte_next     = off_reg[BYTE_W-1:0];
                        cur_next      = cl_reg;
                        walk_ram_next = 1'b0;
                    end
                    fcce_pkg::OP_ALLOC: begin
                        if (cl_reg != '0 && cl_oor) begin
                            rst_next = fcce_pkg::ST_RANGE;
                        end
                        scan_next = CNT_W'(2);
                        pend_next = 1'b0;
                    end
                    default: ;
                endcase
            end
            fcce_pkg::S_RD_WAIT: begin
                rcl_next = ram_rdata;
            end
            // one hop per cycle: check the current cluster, then read its entry
            fcce_pkg::S_WALK: begin
                cur_next      = cur;
                walk_ram_next = 1'b0;
                if (hops_reg != '0) begin
                    if (cur_end) begin
                        rst_next = fcce_pkg::ST_END;
                        rcl_next = cur;
                    end else if (cur_oor) begin
                        rst_next = fcce_pkg::ST_RANGE;
                        rcl_next = cur;
                    end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = cur[ADDR_W-1:0];
                        hops_next     = hops_reg - HOP_W'(1);
                        walk_ram_next = 1'b1;
                    end
                end
            end
            fcce_pkg::S_LOC_END: begin
                rcl_next = cur_reg;
                if (end_end) begin
                    rst_next = fcce_pkg::ST_END;
                end else if (end_oor) begin
                    rst_next = fcce_pkg::ST_RANGE;
                end else begin
                    rsec_next  = (sec_base | SEC_W'(page_reg)) + cfg.data_start;
                    rbyte_next = byte_reg;
                end
            end
            // pipelined scan: issue one read per cycle, test the previous one
            fcce_pkg::S_SCAN: begin
                if (!scan_hit) begin
                    if (scan_more) begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = scan_reg[ADDR_W-1:0];
                        pend_next     = 1'b1;
                        pidx_next     = scan_reg[ADDR_W-1:0];
                        scan_next     = scan_reg + CNT_W'(1);
                    end else begin
                        pend_next = 1'b0;
                        if (!pend_reg) begin
                            rst_next = fcce_pkg::ST_FULL;
                        end
                    end
                end
            end
            fcce_pkg::S_MARK: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = pidx_reg;
                ram_req.wdata = fcce_pkg::END_MARK;
                rcl_next      = CL_W'(pidx_reg);
            end
            fcce_pkg::S_LINK: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = cl_reg[ADDR_W-1:0];
                ram_req.wdata = CL_W'(pidx_reg);
            end
            default: ;
        endcase
    end

    // Output register: holds a result while the next item is taken in
    always_comb begin
        mv_next    = mv_reg;
        ost_next   = ost_reg;
        ocl_next   = ocl_reg;
        osec_next  = osec_reg;
        obyte_next = obyte_reg;
        if (out_load) begin
            mv_next    = 1'b1;
            ost_next   = rst_reg;
            ocl_next   = rcl_reg;
            osec_next  = rsec_reg;
            obyte_next = rbyte_reg;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fcce_pkg::S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        cl_reg       <= cl_next;
        val_reg      <= val_next;
        off_reg      <= off_next;
        hops_reg     <= hops_next;
        page_reg     <= page_next;
        byte_reg     <= byte_next;
        cur_reg      <= cur_next;
        walk_ram_reg <= walk_ram_next;
        scan_reg     <= scan_next;
        pend_reg     <= pend_next;
        pidx_reg     <= pidx_next;
        rst_reg      <= rst_next;
        rcl_reg      <= rcl_next;
        rsec_reg     <= rsec_next;
        rbyte_reg    <= rbyte_next;
        ost_reg      <= ost_next;
        ocl_reg      <= ocl_next;
        osec_reg     <= osec_next;
        obyte_reg    <= obyte_next;
    end

    assign m_valid          = mv_reg;
    assign m_status         = ost_reg;
    assign m_cluster_out    = ocl_reg;
    assign m_sector         = osec_reg;
    assign m_byte_in_sector = obyte_reg;

endmodule

FILE: design/fat16_cluster_chain_engine.sv
// FAT16 cluster chain engine. Keeps a 4096-entry table of 16-bit FAT entries in one
// synchronous RAM and serves one transaction at a time: write entry, read entry,
// locate (walk a chain and turn a byte offset into sector and byte) and allocate-and-link
// (take the first zero entry from cluster 2 up, mark it end of chain, link it to the
// given cluster if that is nonzero). The op travels on s_tuser, the status on m_tuser.
// The single RAM read port serves one table read per cycle; locate reads one entry per
// hop, where hops is offset / (512 * sectors per cluster), and allocate reads the
// entries from 2 up until a free one is found or the usable table ends. The
// table has no reset and no clearing pass: software loads every entry below
// entries_in_use first. A finished result waits in an output register, so the next
// transaction is taken meanwhile.
// Depends on fcce_pkg, fcce_cfg, fcce_ctrl and fcce_ram.
`timescale 1ns / 1ps

module fat16_cluster_chain_engine (
    input  logic        aclk,
    input  logic        aresetn,
    // operation input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [15:0] cluster, [31:16] entry_value, [63:32] offset
    input  logic [1:0]  s_tuser,    // [1:0] op
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [15:0] cluster_out, [47:16] sector,
                                    // [56:48] byte_in_sector, [63:57] zero
    output logic [1:0]  m_tuser,    // [1:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    fcce_pkg::cfg_t                          cfg;
    fcce_pkg::ram_req_t                      ram_req;
    logic [fcce_pkg::CL_W-1:0]               ram_rdata;
    fcce_pkg::status_t                       m_status;
    logic [fcce_pkg::CL_W-1:0]               m_cluster_out;
    logic [fcce_pkg::SEC_W-1:0]              m_sector;
    logic [fcce_pkg::BYTE_W-1:0]             m_byte_in_sector;

    fcce_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fcce_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .s_valid          (s_tvalid),
        .s_ready          (s_tready),
        .s_op             (fcce_pkg::op_t'(s_tuser)),
        .s_cluster        (s_tdata[15:0]),
        .s_entry_value    (s_tdata[31:16]),
        .s_offset         (s_tdata[63:32]),
        .m_valid          (m_tvalid),
        .m_ready          (m_tready),
        .m_status         (m_status),
        .m_cluster_out    (m_cluster_out),
        .m_sector         (m_sector),
        .m_byte_in_sector (m_byte_in_sector),
        .ram_req          (ram_req),
        .ram_rdata        (ram_rdata)
    );

    fcce_ram #(
        .DEPTH (fcce_pkg::TABLE_DEPTH),
        .WIDTH (fcce_pkg::CL_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Result packing
    assign m_tdata = {7'd0, m_byte_in_sector, m_sector, m_cluster_out};
    assign m_tuser = m_status;

`ifndef SYNTHESIS
    // one transaction in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a transaction is in flight");

    // a new result is loaded only from the response state, never while idle
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a transaction in flight");

    // table writes stay inside the entries in use
    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_req.we |-> (fcce_pkg::CNT_W'(ram_req.waddr) < cfg.usable))
        else $error("table write beyond the entries in use");
`endif

endmodule
